// ----- sv/ipd_pkg.sv -----
package ipd_pkg;

    // Default width of the decimal frame length counter.
    localparam int LENGTH_WIDTH_DEF = 16;

    // Reset value of the start byte register.
    localparam logic [7:0] START_BYTE_RST = 8'h42;

    // Characters of the outer frame.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [3:0] DEC_BASE   = 4'd10;

    // Header text "+IPD," and its length.
    localparam logic [2:0] HDR_LEN = 3'd5;

    typedef enum logic [1:0] {
        OUT_HUNT = 2'd0,
        OUT_LEN  = 2'd1,
        OUT_DATA = 2'd2
    } outer_phase_t;

    typedef enum logic [1:0] {
        IN_WAIT = 2'd0,
        IN_ID   = 2'd1,
        IN_LEN  = 2'd2,
        IN_DATA = 2'd3
    } inner_phase_t;

    // One result item as it leaves the inner layer.
    typedef struct packed {
        logic [7:0] packet_id;
        logic [7:0] packet_length;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_of_packet;
    } pkt_result_t;

    // Handoff from the outer layer to the inner layer.
    typedef struct packed {
        logic       take;
        logic [7:0] frame_byte;
    } frame_xfer_t;

    // Status from the inner layer back to the outer layer.
    typedef struct packed {
        logic emit;
        logic done;
    } inner_status_t;

    // Expected header character at a given match position.
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h2B;
            3'd1:    ch = 8'h49;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h44;
            3'd4:    ch = 8'h2C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- sv/ipd_outer.sv -----
module ipd_outer #(
    parameter int LENGTH_WIDTH = ipd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    input  ipd_pkg::inner_status_t inner_status,
    output ipd_pkg::frame_xfer_t  xfer
);
    import ipd_pkg::*;

    localparam int PROD_WIDTH = LENGTH_WIDTH + 4;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

    outer_phase_t            phase_reg, phase_next;
    logic [2:0]              pos_reg, pos_next;
    logic [LENGTH_WIDTH-1:0] rem_reg, rem_next;

    logic [2:0]              pos_eff;
    logic [PROD_WIDTH-1:0]   rem_ext;
    logic [PROD_WIDTH-1:0]   rem_prod;
    logic [LENGTH_WIDTH-1:0] rem_sat;
    logic [LENGTH_WIDTH-1:0] rem_dec;
    logic                    is_digit;

    // Decimal accumulate: rem * 10 + digit, saturated to the counter width.
    assign rem_ext  = {4'b0, rem_reg};
    assign rem_prod = (rem_ext << 3) + (rem_ext << 1) + {{LENGTH_WIDTH{1'b0}}, rx_byte[3:0]};
    assign rem_sat  = (rem_prod[PROD_WIDTH-1:LENGTH_WIDTH] != 4'd0)
                      ? LEN_MAX : rem_prod[LENGTH_WIDTH-1:0];
    assign rem_dec  = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign pos_eff  = (pos_reg > (HDR_LEN - 3'd1)) ? 3'd0 : pos_reg;

    // Frame bytes go inward only in the data phase.
    assign xfer.take       = step && (phase_reg == OUT_DATA);
    assign xfer.frame_byte = rx_byte;

    // Next state of the header hunt, length reader and frame counter.
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        if (step)
        begin
            unique case (phase_reg)
                OUT_LEN:
                begin
                    if (rx_byte == CHAR_COLON)
                    begin
                        phase_next = (rem_reg == '0) ? OUT_HUNT : OUT_DATA;
                    end
                    else if (is_digit)
                    begin
                        rem_next = rem_sat;
                    end
                    else
                    begin
                        phase_next = OUT_HUNT;
                        pos_next   = 3'd0;
                        rem_next   = '0;
                    end
                end
                OUT_DATA:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0 || inner_status.done)
                    begin
                        phase_next = OUT_HUNT;
                        pos_next   = 3'd0;
                        rem_next   = '0;
                    end
                end
                default:
                begin
                    // Header hunt; the unused phase code lands here too.
                    phase_next = OUT_HUNT;
                    if (rx_byte == hdr_char(pos_eff))
                    begin
                        if (pos_eff == HDR_LEN - 3'd1)
                        begin
                            pos_next   = 3'd0;
                            rem_next   = '0;
                            phase_next = OUT_LEN;
                        end
                        else
                        begin
                            pos_next = pos_eff + 3'd1;
                        end
                    end
                    else
                    begin
                        pos_next = 3'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= OUT_HUNT;
            pos_reg   <= 3'd0;
            rem_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

// ----- sv/ipd_inner.sv -----
module ipd_inner (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ipd_pkg::frame_xfer_t   xfer,
    input  logic [7:0]             start_byte,
    output ipd_pkg::inner_status_t status,
    output ipd_pkg::pkt_result_t   result
);
    import ipd_pkg::*;

    inner_phase_t phase_reg, phase_next;
    logic [7:0]   id_reg, id_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   seen_reg, seen_next;
    logic [7:0]   seen_inc;

    assign seen_inc = seen_reg + 8'd1;

    // Packet parse and result forming for one frame byte.
    always_comb
    begin
        phase_next = phase_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        status     = '0;
        result.packet_id      = id_reg;
        result.packet_length  = len_reg;
        result.data_byte      = xfer.frame_byte;
        result.byte_valid     = 1'b1;
        result.last_of_packet = 1'b0;
        if (xfer.take)
        begin
            unique case (phase_reg)
                IN_WAIT:
                begin
                    if (xfer.frame_byte == start_byte)
                    begin
                        phase_next = IN_ID;
                    end
                end
                IN_ID:
                begin
                    id_next    = xfer.frame_byte;
                    phase_next = IN_LEN;
                end
                IN_LEN:
                begin
                    len_next  = xfer.frame_byte;
                    seen_next = 8'd0;
                    if (xfer.frame_byte == 8'd0)
                    begin
                        // Empty packet: one result with no payload.
                        status.emit           = 1'b1;
                        status.done           = 1'b1;
                        result.packet_length  = 8'd0;
                        result.data_byte      = 8'd0;
                        result.byte_valid     = 1'b0;
                        result.last_of_packet = 1'b1;
                        phase_next            = IN_WAIT;
                    end
                    else
                    begin
                        phase_next = IN_DATA;
                    end
                end
                IN_DATA:
                begin
                    seen_next   = seen_inc;
                    status.emit = 1'b1;
                    if (seen_inc == len_reg)
                    begin
                        status.done           = 1'b1;
                        result.last_of_packet = 1'b1;
                        phase_next            = IN_WAIT;
                    end
                end
                default:
                begin
                    phase_next = IN_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= IN_WAIT;
            id_reg    <= 8'd0;
            len_reg   <= 8'd0;
            seen_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// ----- sv/ipd_packet_deframer.sv -----
// Channel   Handshake              Payload
// -------   --------------------   ---------------------------------------------
// in        in_valid / in_stall    rx_byte
// out       out_valid / out_stall  packet_id, packet_length, data_byte,
//                                  byte_valid, last_of_packet
// cfg       cfg_valid / cfg_ready  start_byte
//
// An item is registered in the input register on accept and parsed once the result
// register can take a result, which it then holds; one byte per cycle is sustained
// while the output is not stalled, set by the single parse step between the input
// register and the result register. rst_n clears all parser state and sets
// start_byte to 66. A stalled result holds in the output register; the input stalls
// only when the input register is occupied and the output holds a stalled result.
module ipd_packet_deframer #(
    parameter int LENGTH_WIDTH = ipd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] packet_id,
    output logic [7:0] packet_length,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       last_of_packet,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] start_byte
);
    import ipd_pkg::*;

    logic          in_full_reg;
    logic [7:0]    rx_reg;
    logic [7:0]    start_reg;
    logic          out_valid_reg;
    pkt_result_t   res_reg;
    logic          step;
    logic          in_accept;
    frame_xfer_t   xfer;
    inner_status_t inner_status;
    pkt_result_t   result;

    // Parse the held byte whenever the output register can take a result.
    assign step      = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !step;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    ipd_outer #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_outer (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .rx_byte      (rx_reg),
        .inner_status (inner_status),
        .xfer         (xfer)
    );

    ipd_inner u_inner (
        .clk        (clk),
        .rst_n      (rst_n),
        .xfer       (xfer),
        .start_byte (start_reg),
        .status     (inner_status),
        .result     (result)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_BYTE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            start_reg <= start_byte;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (step)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rx_reg <= rx_byte;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= inner_status.emit;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && inner_status.emit)
        begin
            res_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign packet_id      = res_reg.packet_id;
    assign packet_length  = res_reg.packet_length;
    assign data_byte      = res_reg.data_byte;
    assign byte_valid     = res_reg.byte_valid;
    assign last_of_packet = res_reg.last_of_packet;

    // An empty-packet result is always the last one and carries a zero data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last_of_packet && data_byte == 8'd0)
        else $error("empty result without last mark or with data");

    // The input only stalls while a byte is held and cannot be parsed.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_full_reg && out_valid_reg && out_stall)
        else $error("input stalled without cause");

    // A new result only appears after a parse step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step))
        else $error("result appeared without a parse step");

    // Frame bytes reach the inner layer only during a parse step.
    assert property (@(posedge clk) disable iff (!rst_n)
        xfer.take |-> step)
        else $error("frame byte passed inward without a parse step");

endmodule
